[hw/rtl/websocket_frame_receiver_top_macros.svh]
// ----------------------------------------------------------------------------
// WebSocket frame receiver assertion macros
// Shared concurrent assertion forms for the receiver modules.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_RECEIVER_TOP_MACROS_SVH
`define WEBSOCKET_FRAME_RECEIVER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WFR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/wfr_pkg.sv]
// ----------------------------------------------------------------------------
// WebSocket frame receiver package
// Types, event codes, parser phases and configuration constants.
// ----------------------------------------------------------------------------
package wfr_pkg;

    localparam int CFG_W     = 14;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_MSG   = 2'd1;

    localparam logic [CFG_W-1:0] MAX_FRAME_RESET = 14'd9000;
    localparam logic [CFG_W-1:0] MAX_MSG_RESET   = 14'd9100;

    localparam logic [2:0] PH_HDR0 = 3'd0;
    localparam logic [2:0] PH_HDR1 = 3'd1;
    localparam logic [2:0] PH_EXT  = 3'd2;
    localparam logic [2:0] PH_KEY  = 3'd3;
    localparam logic [2:0] PH_BODY = 3'd4;
    localparam logic [2:0] PH_STOP = 3'd5;

    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    localparam logic [6:0] LEN7_16BIT = 7'd126;
    localparam logic [6:0] LEN7_64BIT = 7'd127;

    localparam logic [3:0] EV_TEXT       = 4'd0;
    localparam logic [3:0] EV_PING       = 4'd2;
    localparam logic [3:0] EV_TEXT_END   = 4'd3;
    localparam logic [3:0] EV_EMPTY_PING = 4'd5;
    localparam logic [3:0] EV_PONG       = 4'd6;
    localparam logic [3:0] EV_CLOSE      = 4'd7;
    localparam logic [3:0] EV_TOO_LONG   = 4'd8;

    typedef struct packed {
        logic [3:0] event_res;
        logic [7:0] data;
        logic       msg_first;
        logic       msg_last;
    } t_result;

endpackage

[hw/rtl/wfr_cfg.sv]
// ----------------------------------------------------------------------------
// WebSocket frame receiver configuration registers
// Decodes register writes into the frame and message length limits.
// ----------------------------------------------------------------------------
module wfr_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [wfr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [wfr_pkg::CFG_W-1:0]     i_cfg_data,
    output logic [wfr_pkg::CFG_W-1:0]     o_max_frame,
    output logic [wfr_pkg::CFG_W-1:0]     o_max_msg
);
    import wfr_pkg::*;

    logic [CFG_W-1:0] r_max_frame;
    logic [CFG_W-1:0] r_max_msg;

    assign o_cfg_ready = 1'b1;
    assign o_max_frame = r_max_frame;
    assign o_max_msg   = r_max_msg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_frame <= MAX_FRAME_RESET;
            r_max_msg   <= MAX_MSG_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MAX_FRAME: r_max_frame <= i_cfg_data;
                REG_MAX_MSG:   r_max_msg   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

[hw/rtl/wfr_parser.sv]
// ----------------------------------------------------------------------------
// WebSocket frame receiver parser
// Holds the frame and fragment state and works out one byte per step.
// ----------------------------------------------------------------------------
module wfr_parser #(
    parameter int LEN_WIDTH = 14
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,
    input  logic                      i_kind,
    input  logic [7:0]                i_rx_byte,
    input  logic [wfr_pkg::CFG_W-1:0] i_max_frame,
    input  logic [wfr_pkg::CFG_W-1:0] i_max_msg,
    output logic                      o_res_valid,
    output wfr_pkg::t_result          o_res
);
    import wfr_pkg::*;

    localparam int WW = (LEN_WIDTH > CFG_W) ? LEN_WIDTH : CFG_W;

    logic [2:0]           r_phase,         n_phase;
    logic                 r_fin,           n_fin;
    logic [3:0]           r_opcode,        n_opcode;
    logic                 r_mask_present,  n_mask_present;
    logic [2:0]           r_ext_cnt,       n_ext_cnt;
    logic [LEN_WIDTH-1:0] r_plen,          n_plen;
    logic                 r_too_big,       n_too_big;
    logic [31:0]          r_key,           n_key;
    logic [LEN_WIDTH-1:0] r_pidx,          n_pidx;
    logic                 r_skip,          n_skip;
    logic                 r_frag_active,   n_frag_active;
    logic                 r_frag_bin,      n_frag_bin;
    logic [CFG_W-1:0]     r_frag_len,      n_frag_len;
    logic                 r_msg_started,   n_msg_started;

    logic [6:0]           l7;
    logic [LEN_WIDTH+7:0] plen_shift;
    logic [LEN_WIDTH:0]   idx_inc;
    logic                 at_end;
    logic [7:0]           key_byte;
    logic [7:0]           unmasked;
    logic [WW-1:0]        pl_wide;
    logic [CFG_W-1:0]     pl_cfg;
    logic [CFG_W:0]       frag_sum;
    logic                 hdr_done;
    logic                 skip_end;
    logic                 res_valid;
    t_result              res;

    assign l7         = i_rx_byte[6:0];
    assign plen_shift = {r_plen, i_rx_byte};
    assign idx_inc    = {1'b0, r_pidx} + {{LEN_WIDTH{1'b0}}, 1'b1};
    assign at_end     = (idx_inc >= {1'b0, r_plen});
    assign unmasked   = i_rx_byte ^ key_byte;

    always_comb begin
        case (r_pidx[1:0])
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
    end

    always_comb begin
        n_phase        = r_phase;
        n_fin          = r_fin;
        n_opcode       = r_opcode;
        n_mask_present = r_mask_present;
        n_ext_cnt      = r_ext_cnt;
        n_plen         = r_plen;
        n_too_big      = r_too_big;
        n_key          = r_key;
        n_pidx         = r_pidx;
        n_skip         = r_skip;
        n_frag_active  = r_frag_active;
        n_frag_bin     = r_frag_bin;
        n_frag_len     = r_frag_len;
        n_msg_started  = r_msg_started;
        hdr_done       = 1'b0;
        skip_end       = 1'b0;
        res_valid      = 1'b0;
        res            = '0;
        pl_wide        = '0;
        pl_cfg         = '0;
        frag_sum       = '0;

        if (i_step) begin
            if (i_kind) begin
                n_phase        = PH_HDR0;
                n_fin          = 1'b0;
                n_opcode       = '0;
                n_mask_present = 1'b0;
                n_ext_cnt      = '0;
                n_plen         = '0;
                n_too_big      = 1'b0;
                n_key          = '0;
                n_pidx         = '0;
                n_skip         = 1'b0;
                n_frag_active  = 1'b0;
                n_frag_bin     = 1'b0;
                n_frag_len     = '0;
                n_msg_started  = 1'b0;
            end else begin
                case (r_phase)
                    PH_HDR0: begin
                        n_fin    = i_rx_byte[7];
                        n_opcode = i_rx_byte[3:0];
                        n_phase  = PH_HDR1;
                    end
                    PH_HDR1: begin
                        n_mask_present = i_rx_byte[7];
                        n_key          = '0;
                        n_too_big      = 1'b0;
                        if (l7 == LEN7_16BIT || l7 == LEN7_64BIT) begin
                            n_plen    = '0;
                            n_ext_cnt = (l7 == LEN7_16BIT) ? 3'd1 : 3'd7;
                            n_phase   = PH_EXT;
                        end else begin
                            n_plen = LEN_WIDTH'(l7);
                            if (i_rx_byte[7]) begin
                                n_ext_cnt = 3'd3;
                                n_phase   = PH_KEY;
                            end else begin
                                hdr_done = 1'b1;
                            end
                        end
                    end
                    PH_EXT: begin
                        if (r_plen[LEN_WIDTH-1 -: 8] != 8'd0) begin
                            n_too_big = 1'b1;
                        end
                        n_plen = plen_shift[LEN_WIDTH-1:0];
                        if (r_ext_cnt != 3'd0) begin
                            n_ext_cnt = r_ext_cnt - 3'd1;
                        end else if (r_mask_present) begin
                            n_ext_cnt = 3'd3;
                            n_phase   = PH_KEY;
                        end else begin
                            hdr_done = 1'b1;
                        end
                    end
                    PH_KEY: begin
                        n_key = {r_key[23:0], i_rx_byte};
                        if (r_ext_cnt != 3'd0) begin
                            n_ext_cnt = r_ext_cnt - 3'd1;
                        end else begin
                            hdr_done = 1'b1;
                        end
                    end
                    PH_BODY: begin
                        n_pidx = idx_inc[LEN_WIDTH-1:0];
                        if (r_skip) begin
                            skip_end = at_end;
                        end else begin
                            if (at_end) begin
                                n_phase = PH_HDR0;
                            end
                            res_valid = 1'b1;
                            res.data  = unmasked;
                            if (r_opcode == OP_PING) begin
                                res.event_res = EV_PING;
                                res.msg_first = (r_pidx == '0);
                                res.msg_last  = at_end;
                            end else begin
                                res.event_res = EV_TEXT + {3'b000, r_frag_bin};
                                res.msg_first = !r_msg_started;
                                res.msg_last  = at_end && r_fin;
                                n_msg_started = 1'b1;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        if (hdr_done) begin
            pl_wide  = WW'(n_plen);
            pl_cfg   = pl_wide[CFG_W-1:0];
            frag_sum = {1'b0, r_frag_len} + {1'b0, pl_cfg};
            n_pidx   = '0;
            n_skip   = 1'b1;
            if (n_too_big || pl_wide > WW'(i_max_frame)) begin
                n_phase       = PH_STOP;
                res_valid     = 1'b1;
                res.event_res = EV_TOO_LONG;
            end else begin
                if (n_opcode == OP_TEXT || n_opcode == OP_BINARY) begin
                    n_skip        = 1'b0;
                    n_frag_bin    = (n_opcode == OP_BINARY);
                    n_frag_active = !n_fin;
                    n_frag_len    = n_fin ? '0 : pl_cfg;
                    n_msg_started = 1'b0;
                end else if (n_opcode == OP_CONT) begin
                    if (r_frag_active && frag_sum <= {1'b0, i_max_msg}) begin
                        n_skip     = 1'b0;
                        n_frag_len = frag_sum[CFG_W-1:0];
                        if (n_fin) begin
                            n_frag_active = 1'b0;
                        end
                    end
                end else if (n_opcode == OP_PING) begin
                    n_skip = 1'b0;
                end
                if (n_plen != '0) begin
                    n_phase = PH_BODY;
                end else begin
                    n_phase = PH_HDR0;
                    if (n_skip) begin
                        skip_end = 1'b1;
                    end else if (n_opcode == OP_PING) begin
                        res_valid     = 1'b1;
                        res.event_res = EV_EMPTY_PING;
                        res.msg_first = 1'b1;
                        res.msg_last  = 1'b1;
                    end else if (n_fin) begin
                        res_valid     = 1'b1;
                        res.event_res = EV_TEXT_END + {3'b000, n_frag_bin};
                        res.msg_first = !n_msg_started;
                        res.msg_last  = 1'b1;
                    end
                end
            end
        end

        if (skip_end) begin
            n_phase = PH_HDR0;
            if (n_opcode == OP_CLOSE) begin
                n_phase       = PH_STOP;
                res_valid     = 1'b1;
                res.event_res = EV_CLOSE;
            end else if (n_opcode == OP_PONG) begin
                res_valid     = 1'b1;
                res.event_res = EV_PONG;
            end
        end
    end

    assign o_res_valid = res_valid;
    assign o_res       = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HDR0;
            r_fin          <= 1'b0;
            r_opcode       <= '0;
            r_mask_present <= 1'b0;
            r_ext_cnt      <= '0;
            r_plen         <= '0;
            r_too_big      <= 1'b0;
            r_key          <= '0;
            r_pidx         <= '0;
            r_skip         <= 1'b0;
            r_frag_active  <= 1'b0;
            r_frag_bin     <= 1'b0;
            r_frag_len     <= '0;
            r_msg_started  <= 1'b0;
        end else begin
            r_phase        <= n_phase;
            r_fin          <= n_fin;
            r_opcode       <= n_opcode;
            r_mask_present <= n_mask_present;
            r_ext_cnt      <= n_ext_cnt;
            r_plen         <= n_plen;
            r_too_big      <= n_too_big;
            r_key          <= n_key;
            r_pidx         <= n_pidx;
            r_skip         <= n_skip;
            r_frag_active  <= n_frag_active;
            r_frag_bin     <= n_frag_bin;
            r_frag_len     <= n_frag_len;
            r_msg_started  <= n_msg_started;
        end
    end

endmodule

[hw/rtl/websocket_frame_receiver_top.sv]
// The receiver takes one link byte or restart request per cycle unless input stall is high,
// and gives at most one result per request. An accepted request sits in the input register
// while the single-pass parse logic works on it, and the result register captures the
// outcome when it is empty or the output is not stalled. The result register lets the next request
// in while a result is still waiting to be taken; input stall rises only when both the
// input and result registers are held by a stalled output.
// ----------------------------------------------------------------------------
// WebSocket frame receiver top level
// Input register, frame parser, configuration registers and result register.
// ----------------------------------------------------------------------------
`include "websocket_frame_receiver_top_macros.svh"

module websocket_frame_receiver_top #(
    parameter int LEN_WIDTH = 14
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_kind,
    input  logic [7:0]                    i_rx_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [3:0]                    o_event_res,
    output logic [7:0]                    o_data,
    output logic                          o_msg_first,
    output logic                          o_msg_last,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [wfr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [wfr_pkg::CFG_W-1:0]     i_cfg_data
);
    import wfr_pkg::*;

    logic             r_in_valid;
    logic             r_kind;
    logic [7:0]       r_byte;
    logic             r_out_valid;
    t_result          r_res;
    logic             proceed;
    logic             step;
    logic             res_valid;
    t_result          res;
    logic [CFG_W-1:0] max_frame;
    logic [CFG_W-1:0] max_msg;

    assign proceed    = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && proceed;
    assign o_in_stall = r_in_valid && !proceed;

    wfr_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_max_frame (max_frame),
        .o_max_msg   (max_msg)
    );

    wfr_parser #(
        .LEN_WIDTH (LEN_WIDTH)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_kind      (r_kind),
        .i_rx_byte   (r_byte),
        .i_max_frame (max_frame),
        .i_max_msg   (max_msg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_kind <= i_kind;
            r_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proceed) begin
            r_out_valid <= step && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proceed && step && res_valid) begin
            r_res <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_event_res = r_res.event_res;
    assign o_data      = r_res.data;
    assign o_msg_first = r_res.msg_first;
    assign o_msg_last  = r_res.msg_last;

    `WFR_ASSERT_NEXT(a_restart_silent, i_clk, i_rst_n,
        step && r_kind, !r_out_valid,
        "restart request produced a result")
    `WFR_ASSERT_SAME(a_event_range, i_clk, i_rst_n,
        o_out_valid, o_event_res <= EV_TOO_LONG,
        "event code out of range")
    `WFR_ASSERT_SAME(a_ctrl_no_data, i_clk, i_rst_n,
        o_out_valid && o_event_res >= EV_TEXT_END, o_data == 8'd0,
        "non-data event carries data")
    `WFR_ASSERT_SAME(a_ctrl_no_flags, i_clk, i_rst_n,
        o_out_valid && o_event_res >= EV_PONG, !o_msg_first && !o_msg_last,
        "control event carries message flags")

endmodule

[dv/tb_websocket_frame_receiver_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// WebSocket frame receiver testbench
// Streams directed and random frames with random gaps and output stalls across
// several limit settings, and checks every event against an in-bench parser.
// ----------------------------------------------------------------------------
module tb_websocket_frame_receiver_top;

    import wfr_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 9;
    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 1000000;

    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    localparam logic [3:0] OP_RESERVED = 4'h3;

    localparam int LEN_ENC_7  = 0;
    localparam int LEN_ENC_16 = 1;
    localparam int LEN_ENC_64 = 2;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } t_link_req;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 i_kind      = 1'b0;
    logic [7:0]           i_rx_byte   = 8'h00;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    logic [3:0]           o_event_res;
    logic [7:0]           o_data;
    logic                 o_msg_first;
    logic                 o_msg_last;
    logic                 o_cfg_ready;

    websocket_frame_receiver_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .i_rx_byte   (i_rx_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_event_res (o_event_res),
        .o_data      (o_data),
        .o_msg_first (o_msg_first),
        .o_msg_last  (o_msg_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    t_link_req   link_reqs[$];
    t_result     expected_events[$];
    int unsigned reqs_queued     = 0;
    int unsigned link_reqs_sent  = 0;
    int unsigned link_reqs_taken = 0;
    int unsigned reg_writes_done = 0;
    int unsigned mismatch_count  = 0;
    int unsigned cycle_count     = 0;
    int unsigned gap_left        = 0;
    int unsigned calm_items      = 0;
    int unsigned stall_run       = 0;
    logic        stall_hold      = 1'b0;

    // Parser state and limits as the block should hold them.
    logic [2:0]       ph;
    logic             fin_q;
    logic [3:0]       opc_q;
    logic             masked_q;
    logic [2:0]       ext_left;
    logic [13:0]      frame_len;
    logic             len_over;
    logic [31:0]      key_q;
    logic [13:0]      body_idx;
    logic             skip_q;
    logic             frag_on;
    logic             frag_bin;
    logic [13:0]      frag_len;
    logic             msg_begun;
    logic [CFG_W-1:0] lim_frame;
    logic [CFG_W-1:0] lim_msg;

    function automatic void clear_parse_state();
        ph        = PH_HDR0;
        fin_q     = 1'b0;
        opc_q     = OP_CONT;
        masked_q  = 1'b0;
        ext_left  = '0;
        frame_len = '0;
        len_over  = 1'b0;
        key_q     = '0;
        body_idx  = '0;
        skip_q    = 1'b0;
        frag_on   = 1'b0;
        frag_bin  = 1'b0;
        frag_len  = '0;
        msg_begun = 1'b0;
    endfunction

    function automatic void post_event(logic [3:0] ev, logic [7:0] d, logic first, logic last);
        t_result r;
        r.event_res = ev;
        r.data      = d;
        r.msg_first = first;
        r.msg_last  = last;
        expected_events.push_back(r);
    endfunction

    function automatic void end_skipped_frame();
        ph = PH_HDR0;
        if (opc_q == OP_CLOSE) begin
            ph = PH_STOP;
            post_event(EV_CLOSE, 8'h00, 1'b0, 1'b0);
        end else if (opc_q == OP_PONG) begin
            post_event(EV_PONG, 8'h00, 1'b0, 1'b0);
        end
    endfunction

    function automatic void end_header();
        logic [14:0] sum;
        body_idx = '0;
        skip_q   = 1'b1;
        if (len_over || frame_len > lim_frame) begin
            ph = PH_STOP;
            post_event(EV_TOO_LONG, 8'h00, 1'b0, 1'b0);
            return;
        end
        if (opc_q == OP_TEXT || opc_q == OP_BINARY) begin
            skip_q    = 1'b0;
            frag_bin  = (opc_q == OP_BINARY);
            frag_on   = !fin_q;
            frag_len  = fin_q ? 14'd0 : frame_len;
            msg_begun = 1'b0;
        end else if (opc_q == OP_CONT) begin
            sum = {1'b0, frag_len} + {1'b0, frame_len};
            if (frag_on && sum <= {1'b0, lim_msg}) begin
                skip_q   = 1'b0;
                frag_len = sum[13:0];
                if (fin_q) frag_on = 1'b0;
            end
        end else if (opc_q == OP_PING) begin
            skip_q = 1'b0;
        end
        if (frame_len != 0) begin
            ph = PH_BODY;
            return;
        end
        ph = PH_HDR0;
        if (skip_q) begin
            end_skipped_frame();
        end else if (opc_q == OP_PING) begin
            post_event(EV_EMPTY_PING, 8'h00, 1'b1, 1'b1);
        end else if (fin_q) begin
            post_event(EV_TEXT_END + frag_bin, 8'h00, !msg_begun, 1'b1);
        end
    endfunction

    function automatic void parse_link_byte(logic kind, logic [7:0] b);
        logic [6:0]  len7;
        logic [13:0] cur_idx;
        logic [7:0]  plain;
        logic        at_end;
        if (kind == KIND_RESTART) begin
            clear_parse_state();
            return;
        end
        case (ph)
            PH_HDR0: begin
                fin_q = b[7];
                opc_q = b[3:0];
                ph    = PH_HDR1;
            end
            PH_HDR1: begin
                len7     = b[6:0];
                masked_q = b[7];
                key_q    = '0;
                len_over = 1'b0;
                if (len7 == LEN7_16BIT || len7 == LEN7_64BIT) begin
                    frame_len = '0;
                    ext_left  = (len7 == LEN7_16BIT) ? 3'd1 : 3'd7;
                    ph        = PH_EXT;
                end else begin
                    frame_len = 14'(len7);
                    if (masked_q) begin
                        ext_left = 3'd3;
                        ph       = PH_KEY;
                    end else begin
                        end_header();
                    end
                end
            end
            PH_EXT: begin
                if (frame_len[13:6] != 0) len_over = 1'b1;
                frame_len = {frame_len[5:0], b};
                if (ext_left != 0) begin
                    ext_left--;
                end else if (masked_q) begin
                    ext_left = 3'd3;
                    ph       = PH_KEY;
                end else begin
                    end_header();
                end
            end
            PH_KEY: begin
                key_q = {key_q[23:0], b};
                if (ext_left != 0) ext_left--;
                else end_header();
            end
            PH_BODY: begin
                cur_idx  = body_idx;
                at_end   = ({1'b0, cur_idx} + 15'd1) >= {1'b0, frame_len};
                plain    = b ^ key_q[8 * (3 - cur_idx[1:0]) +: 8];
                body_idx = cur_idx + 14'd1;
                if (skip_q) begin
                    if (at_end) end_skipped_frame();
                end else begin
                    if (at_end) ph = PH_HDR0;
                    if (opc_q == OP_PING) begin
                        post_event(EV_PING, plain, cur_idx == 0, at_end);
                    end else begin
                        post_event(EV_TEXT + frag_bin, plain, !msg_begun, at_end && fin_q);
                        msg_begun = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void push_byte(logic [7:0] b);
        link_reqs.push_back('{kind: KIND_BYTE, rx_byte: b});
        reqs_queued++;
    endfunction

    function automatic void push_restart();
        link_reqs.push_back('{kind: KIND_RESTART, rx_byte: 8'($urandom)});
        reqs_queued++;
    endfunction

    function automatic void push_frame(logic [7:0] hdr0, logic masked, int unsigned len,
                                       int enc, logic [47:0] len_hi, int unsigned body_n);
        logic [31:0] key;
        logic [15:0] len16;
        logic [63:0] ext;
        key   = $urandom;
        len16 = len[15:0];
        ext   = {len_hi, len16};
        push_byte(hdr0);
        case (enc)
            LEN_ENC_7: begin
                push_byte({masked, 7'(len)});
            end
            LEN_ENC_16: begin
                push_byte({masked, LEN7_16BIT});
                push_byte(len16[15:8]);
                push_byte(len16[7:0]);
            end
            default: begin
                push_byte({masked, LEN7_64BIT});
                for (int i = 7; i >= 0; i--) push_byte(ext[8 * i +: 8]);
            end
        endcase
        if (masked) begin
            for (int i = 3; i >= 0; i--) push_byte(key[8 * i +: 8]);
        end
        for (int unsigned i = 0; i < body_n; i++) push_byte(8'($urandom));
    endfunction

    function automatic void push_random_frame(int unsigned frame_lim);
        int unsigned r;
        int unsigned len;
        int unsigned body_n;
        int          enc;
        logic [3:0]  op;
        logic [2:0]  rsv;
        logic        fin;
        logic        masked;
        logic        cut;
        logic        stops;
        logic [47:0] hi;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            op = $urandom_range(0, 1) ? OP_BINARY : OP_TEXT;
        end else if (r < 60) begin
            op = OP_CONT;
        end else if (r < 72) begin
            op = OP_PING;
        end else if (r < 80) begin
            op = OP_PONG;
        end else if (r < 84) begin
            op = OP_CLOSE;
        end else begin
            do op = 4'($urandom_range(0, 15));
            while (op inside {OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG});
        end
        fin    = ($urandom_range(0, 99) < 60);
        masked = $urandom_range(0, 1);
        rsv    = ($urandom_range(0, 99) < 20) ? 3'($urandom) : 3'b000;
        hi     = '0;
        r = $urandom_range(0, 99);
        if (r < 65) len = $urandom_range(0, 10);
        else if (r < 82) len = (frame_lim > 40) ? $urandom_range(11, 40)
                                                : frame_lim + $urandom_range(0, 1);
        else len = $urandom_range(frame_lim + 1, 65535);
        r = $urandom_range(0, 99);
        if (len > 125) enc = (r < 35) ? LEN_ENC_64 : LEN_ENC_16;
        else if (r < 75) enc = LEN_ENC_7;
        else if (r < 90) enc = LEN_ENC_16;
        else enc = LEN_ENC_64;
        if (enc == LEN_ENC_64 && $urandom_range(0, 99) < 10) begin
            hi = {$urandom, 16'($urandom)};
            if (hi == 0) hi[0] = 1'b1;
        end
        stops  = (op == OP_CLOSE) || hi != 0 || len > frame_lim;
        body_n = (hi != 0 || len > frame_lim) ? 0 : len;
        cut    = ($urandom_range(0, 99) < 4);
        if (cut) body_n = $urandom_range(0, body_n);
        push_frame({fin, rsv, op}, masked, len, enc, hi, body_n);
        if (stops || cut) begin
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
            end
            push_restart();
        end
    endfunction

    function automatic void fill_random(int unsigned count, int unsigned frame_lim);
        int unsigned start;
        start = reqs_queued;
        while (reqs_queued - start < count) begin
            if ($urandom_range(0, 99) < 2) begin
                repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
                push_restart();
            end else begin
                push_random_frame(frame_lim);
            end
        end
    endfunction

    function automatic int unsigned next_gap();
        int unsigned r;
        if (calm_items != 0) begin
            calm_items--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            calm_items = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        int unsigned seen;
        seen = reg_writes_done;
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        wait (reg_writes_done != seen);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (link_reqs.size() != 0 || i_in_valid || expected_events.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin : drive_link
        logic      next_valid;
        t_link_req next_req;
        next_valid = i_in_valid;
        next_req   = '{kind: i_kind, rx_byte: i_rx_byte};
        if (!i_in_valid || link_reqs_taken == link_reqs_sent) begin
            next_valid = 1'b0;
            if (gap_left != 0) begin
                gap_left--;
            end else if (link_reqs.size() != 0) begin
                next_req   = link_reqs.pop_front();
                next_valid = 1'b1;
                link_reqs_sent++;
                gap_left = next_gap();
            end
        end
        i_in_valid <= next_valid;
        i_kind     <= next_req.kind;
        i_rx_byte  <= next_req.rx_byte;
    end

    always @(negedge i_clk) begin : drive_stall
        int unsigned r;
        if (stall_run == 0) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                stall_hold = 1'b0;
                stall_run  = $urandom_range(40, 120);
            end else if (r < 60) begin
                stall_hold = 1'b0;
                stall_run  = $urandom_range(1, 6);
            end else if (r < 92) begin
                stall_hold = 1'b1;
                stall_run  = $urandom_range(1, 3);
            end else begin
                stall_hold = 1'b1;
                stall_run  = $urandom_range(10, 40);
            end
        end
        stall_run--;
        i_out_stall <= stall_hold;
    end

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_MAX_FRAME: lim_frame = i_cfg_data;
                    REG_MAX_MSG:   lim_msg   = i_cfg_data;
                    default: begin
                    end
                endcase
                reg_writes_done++;
            end
            if (i_in_valid && !o_in_stall) begin
                parse_link_byte(i_kind, i_rx_byte);
                link_reqs_taken++;
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_events.size() == 0) begin
                    $error("unexpected result: event_res %0d, data 0x%02h", o_event_res, o_data);
                    mismatch_count++;
                end else begin
                    want = expected_events.pop_front();
                    if (o_event_res !== want.event_res) begin
                        $error("event_res: expected %0d, actual %0d", want.event_res, o_event_res);
                        mismatch_count++;
                    end
                    if (o_data !== want.data) begin
                        $error("data: expected 0x%02h, actual 0x%02h", want.data, o_data);
                        mismatch_count++;
                    end
                    if (o_msg_first !== want.msg_first) begin
                        $error("msg_first: expected %0b, actual %0b", want.msg_first, o_msg_first);
                        mismatch_count++;
                    end
                    if (o_msg_last !== want.msg_last) begin
                        $error("msg_last: expected %0b, actual %0b", want.msg_last, o_msg_last);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin : stimulus
        logic [CFG_W-1:0] frame_lim;
        logic [CFG_W-1:0] msg_lim;
        clear_parse_state();
        lim_frame = MAX_FRAME_RESET;
        lim_msg   = MAX_MSG_RESET;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // An empty non-final fragment gives nothing; its masked final continuation
        // carries a single byte that is both first and last of the message.
        push_frame({1'b0, 3'b000, OP_TEXT}, 1'b0, 0, LEN_ENC_7, '0, 0);
        push_frame({1'b1, 3'b000, OP_CONT}, 1'b1, 1, LEN_ENC_7, '0, 1);
        push_frame({1'b1, 3'b000, OP_CONT}, 1'b0, 0, LEN_ENC_7, '0, 0);
        push_frame({1'b1, 3'b000, OP_PING}, 1'b0, 0, LEN_ENC_7, '0, 0);
        push_byte({1'b1, 3'b111, OP_PING});
        push_byte(8'h02);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_frame({1'b1, 3'b000, OP_PONG}, 1'b0, 0, LEN_ENC_7, '0, 0);
        // A new text frame abandons the open binary message and ends at once.
        push_frame({1'b0, 3'b000, OP_BINARY}, 1'b0, 1, LEN_ENC_7, '0, 1);
        push_frame({1'b1, 3'b000, OP_TEXT}, 1'b0, 0, LEN_ENC_7, '0, 0);
        push_frame({1'b1, 3'b000, OP_RESERVED}, 1'b0, 1, LEN_ENC_7, '0, 1);
        push_frame({1'b1, 3'b000, OP_CLOSE}, 1'b0, 0, LEN_ENC_7, '0, 0);
        push_byte(8'h81);
        push_restart();
        push_frame({1'b1, 3'b000, OP_TEXT}, 1'b0, 16'h4000, LEN_ENC_16, '0, 0);
        push_restart();

        fill_random(450, MAX_FRAME_RESET);
        wait_idle();

        write_reg(REG_MAX_FRAME, 14'd16);
        write_reg(REG_MAX_MSG, 14'd24);
        fill_random(600, 16);
        wait_idle();

        write_reg(REG_MAX_FRAME, 14'd0);
        write_reg(REG_MAX_MSG, 14'd0);
        fill_random(150, 0);
        wait_idle();

        write_reg(REG_MAX_FRAME, 14'h3FFF);
        write_reg(REG_MAX_MSG, 14'h3FFF);
        push_frame({1'b1, 3'b000, OP_BINARY}, 1'b1, 150, LEN_ENC_16, '0, 150);
        fill_random(150, 14'h3FFF);
        wait_idle();

        frame_lim = 14'($urandom_range(1, 60));
        msg_lim   = 14'($urandom_range(0, 120));
        write_reg(REG_MAX_FRAME, frame_lim);
        write_reg(REG_MAX_MSG, msg_lim);
        fill_random(200, frame_lim);
        wait_idle();

        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
